// ===== sv/tsd_pkg.sv =====
// ---------------------------------------------------------------------------
// tsd_pkg
// Shared types and constants for the touch select dimmer.
// ---------------------------------------------------------------------------
package tsd_pkg;

  localparam int unsigned CHANNELS = 4;
  localparam int unsigned DATA_W   = 16;
  localparam int unsigned CH_W     = 2;
  localparam int unsigned CHOSEN_W = 3;
  localparam int unsigned CFG_IDX_W = 3;

  // Chosen-channel code when no channel is above its threshold
  localparam logic [CHOSEN_W-1:0] CHOSEN_NONE = CHOSEN_W'(CHANNELS);

  // Configuration reset values
  localparam logic [DATA_W-1:0] OFFSET_RESET = 16'd20;
  localparam logic [DATA_W-1:0] STEP_RESET   = 16'd100;
  localparam logic [DATA_W-1:0] LEVEL_RESET [CHANNELS] = '{
    16'hFFFF, 16'((32'hFFFF / 3) * 2), 16'(32'hFFFF / 3), 16'h0000
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET = 3'd0,
    REG_STEP   = 3'd1,
    REG_LEVEL0 = 3'd2,
    REG_LEVEL1 = 3'd3,
    REG_LEVEL2 = 3'd4,
    REG_LEVEL3 = 3'd5
  } tsd_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_SEL,
    S_RAMP,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_OUT
  } tsd_state_e;

  typedef struct packed {
    logic [DATA_W-1:0] channel0_signal;
    logic [DATA_W-1:0] channel1_signal;
    logic [DATA_W-1:0] channel2_signal;
    logic [DATA_W-1:0] channel3_signal;
  } tsd_in_t;

  typedef struct packed {
    logic [DATA_W-1:0]   pwm_compare;
    logic [DATA_W-1:0]   duty_now;
    logic [CHOSEN_W-1:0] chosen_channel;
    logic                recalibrated;
  } tsd_out_t;

  typedef struct packed {
    logic load_in;
    logic accum;
    logic select;
    logic ramp;
    logic mul_en;
    logic mul_use_duty;
    logic mul_to_cmp;
    logic load_out;
  } tsd_cmd_t;

  typedef struct packed {
    logic out_stall;
  } tsd_status_t;

endpackage

// ===== sv/tsd_ctrl.sv =====
// ---------------------------------------------------------------------------
// tsd_ctrl
// Sequencer: steps one measurement through accumulate, select, ramp,
// three multiplies and output load.
// ---------------------------------------------------------------------------
module tsd_ctrl import tsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  tsd_status_t status_i,
  output tsd_cmd_t    cmd_o
);

  tsd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.accum = 1'b1;
        state_d     = S_SEL;
      end
      S_SEL: begin
        cmd_o.select = 1'b1;
        state_d      = S_RAMP;
      end
      S_RAMP: begin
        cmd_o.ramp = 1'b1;
        state_d    = S_MUL0;
      end
      S_MUL0: begin
        cmd_o.mul_en       = 1'b1;
        cmd_o.mul_use_duty = 1'b1;
        state_d            = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul_en     = 1'b1;
        cmd_o.mul_to_cmp = 1'b1;
        state_d          = S_OUT;
      end
      S_OUT: begin
        // hold until the output register can take the result
        if (!status_i.out_stall) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  a_load_not_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> !status_i.out_stall)
    else $error("result loaded over a stalled result");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_ACC)
    else $error("accepted item did not start accumulation");

  a_mul_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul_to_cmp |-> $past(cmd_o.mul_en) && !$past(cmd_o.mul_to_cmp))
    else $error("compare written without preceding multiply");

endmodule

// ===== sv/tsd_dp.sv =====
// ---------------------------------------------------------------------------
// tsd_dp
// Datapath: window sums, thresholds, channel selection, duty ramp,
// shared 16x16 multiplier for duty^4, and the output register.
// ---------------------------------------------------------------------------
module tsd_dp import tsd_pkg::*; #(
  parameter int unsigned WINDOW_LOG2 = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tsd_cmd_t             cmd_i,
  output tsd_status_t          status_o,
  input  tsd_in_t              in_data_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tsd_out_t             out_data_o
);

  localparam int unsigned SUM_W = DATA_W + WINDOW_LOG2;

  // configuration
  logic [DATA_W-1:0] offset_q, step_q;
  logic [DATA_W-1:0] levels_q [CHANNELS];

  // state
  logic [SUM_W-1:0]       sums_q   [CHANNELS];
  logic [DATA_W-1:0]      thresh_q [CHANNELS];
  logic [WINDOW_LOG2-1:0] count_q;
  logic [DATA_W-1:0]      duty_q, target_q, cmp_q;

  // per-item working registers
  logic [DATA_W-1:0]   sig_q [CHANNELS];
  logic [DATA_W-1:0]   prod_q;
  logic [CHOSEN_W-1:0] chosen_q;
  logic                recal_q;

  logic                 out_valid_q;
  tsd_out_t             out_q;

  // -------------------------------------------------------------------------
  // Configuration writes
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OFFSET_RESET;
      step_q   <= STEP_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
        levels_q[i] <= LEVEL_RESET[i];
      end
    end else if (cfg_we_i) begin
      case (tsd_reg_e'(cfg_idx_i))
        REG_OFFSET: offset_q    <= cfg_data_i;
        REG_STEP:   step_q      <= cfg_data_i;
        REG_LEVEL0: levels_q[0] <= cfg_data_i;
        REG_LEVEL1: levels_q[1] <= cfg_data_i;
        REG_LEVEL2: levels_q[2] <= cfg_data_i;
        REG_LEVEL3: levels_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Input capture
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      sig_q[0] <= in_data_i.channel0_signal;
      sig_q[1] <= in_data_i.channel1_signal;
      sig_q[2] <= in_data_i.channel2_signal;
      sig_q[3] <= in_data_i.channel3_signal;
    end
  end

  // -------------------------------------------------------------------------
  // Window accumulation and threshold refresh
  // -------------------------------------------------------------------------
  logic [SUM_W-1:0]  sum_add [CHANNELS];
  logic [DATA_W:0]   th_raw  [CHANNELS];
  logic [DATA_W-1:0] th_sat  [CHANNELS];
  logic              window_last;

  assign window_last = (count_q == {WINDOW_LOG2{1'b1}});

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      sum_add[i] = sums_q[i] + SUM_W'(sig_q[i]);
      th_raw[i]  = {1'b0, sum_add[i][SUM_W-1:WINDOW_LOG2]} + {1'b0, offset_q};
      th_sat[i]  = th_raw[i][DATA_W] ? {DATA_W{1'b1}} : th_raw[i][DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      recal_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        sums_q[i]   <= '0;
        thresh_q[i] <= '0;
      end
    end else if (cmd_i.accum) begin
      recal_q <= window_last;
      count_q <= window_last ? '0 : count_q + 1'b1;
      for (int i = 0; i < CHANNELS; i++) begin
        sums_q[i] <= window_last ? '0 : sum_add[i];
        if (window_last) begin
          thresh_q[i] <= th_sat[i];
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Selection: largest positive excess, first channel wins ties
  // -------------------------------------------------------------------------
  logic [DATA_W-1:0]   best;
  logic [DATA_W-1:0]   diff;
  logic [CHOSEN_W-1:0] chosen;

  always_comb begin
    best   = '0;
    chosen = CHOSEN_NONE;
    for (int i = 0; i < CHANNELS; i++) begin
      diff = (sig_q[i] > thresh_q[i]) ? sig_q[i] - thresh_q[i] : '0;
      if (diff > best) begin
        best   = diff;
        chosen = CHOSEN_W'(i);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Target, ramp and duty^4
  // -------------------------------------------------------------------------
  logic [DATA_W-1:0] duty_gap;
  logic [DATA_W:0]   step2;
  logic [DATA_W-1:0] duty_next;
  logic [DATA_W-1:0] mul_a;
  logic [2*DATA_W-1:0] product;

  always_comb begin
    duty_gap = (duty_q > target_q) ? duty_q - target_q : target_q - duty_q;
    step2    = {step_q, 1'b0};
    if ({1'b0, duty_gap} < step2) begin
      duty_next = target_q;
    end else if (duty_q > target_q) begin
      duty_next = duty_q - step_q;
    end else begin
      duty_next = duty_q + step_q;
    end
    mul_a   = cmd_i.mul_use_duty ? duty_q : prod_q;
    product = mul_a * duty_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      duty_q   <= '0;
      cmp_q    <= '0;
    end else begin
      if (cmd_i.select && chosen != CHOSEN_NONE) begin
        target_q <= levels_q[chosen[CH_W-1:0]];
      end
      if (cmd_i.ramp) begin
        duty_q <= duty_next;
      end
      if (cmd_i.mul_en && cmd_i.mul_to_cmp) begin
        cmp_q <= product[2*DATA_W-1:DATA_W];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.select) begin
      chosen_q <= chosen;
    end
    if (cmd_i.mul_en && !cmd_i.mul_to_cmp) begin
      prod_q <= product[2*DATA_W-1:DATA_W];
    end
  end

  // -------------------------------------------------------------------------
  // Output register
  // -------------------------------------------------------------------------
  assign status_o.out_stall = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.pwm_compare    <= cmp_q;
      out_q.duty_now       <= duty_q;
      out_q.chosen_channel <= chosen_q;
      out_q.recalibrated   <= recal_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_window_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accum && window_last |=> count_q == '0 && recal_q)
    else $error("window did not wrap on its last sample");

  a_ramp_down_no_overshoot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ramp && duty_q >= target_q |=> duty_q >= target_q)
    else $error("duty ramped below target");

  a_ramp_up_no_overshoot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ramp && duty_q <= target_q |=> duty_q <= target_q)
    else $error("duty ramped above target");

endmodule

// ===== sv/touch_select_dimmer.sv =====
// ---------------------------------------------------------------------------
// touch_select_dimmer
// Capacitive four-button selector driving a ramped, fourth-power dimmer.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_ready_o, one transfer per finished
//   four-channel measurement (in_data_i). Output channel: out_valid_o /
//   out_ready_i, exactly one result transfer per measurement (out_data_o).
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 offset, 1 ramp step, 2..5 channel levels) in the same cycle; write
//   only while no measurement is in flight. Other indexes are dropped.
//   The result is loaded into the output register once the sequencer has
//   stepped accumulate, select, ramp and three passes of the shared 16x16
//   multiplier (duty^4); a new measurement is accepted only after that
//   output load, so measurements are processed one at a time.
//   The output register decouples the sides: the next measurement is taken
//   while a result still waits; if the receiver stalls, the sequencer holds
//   the following result until the output register frees.
//   Reset (rst_ni low, asynchronous) restores the configuration defaults and
//   clears sums, thresholds, window count, duty, target and compare value.
// ---------------------------------------------------------------------------
module touch_select_dimmer import tsd_pkg::*; #(
  parameter int unsigned WINDOW_LOG2 = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tsd_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tsd_out_t             out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  // command and status between the sequencer and the datapath
  tsd_cmd_t    cmd;
  tsd_status_t status;

  tsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath holds all per-item state plus the output register
  tsd_dp #(
    .WINDOW_LOG2 (WINDOW_LOG2)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
